>>> rtl/lpht_pkg.sv
// ============================================================================
// lpht_pkg
// Shared constants, codes and controller/datapath interface types for the
// linear probing hash table.
// ============================================================================
`default_nettype none

package lpht_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_BYTES = 8;
    localparam int SLOTS     = 2 * CAPACITY;

    localparam int KEY_W   = 64;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int SLOT_W  = CNT_W + 1;
    localparam int BYTE_W  = 3;

    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    // 64-bit FNV-1a; the slot index only needs the low bits of the hash
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
    localparam logic [SLOT_AW-1:0] FNV_BASIS_LO = FNV_BASIS[SLOT_AW-1:0];
    localparam logic [SLOT_AW-1:0] FNV_PRIME_LO = FNV_PRIME[SLOT_AW-1:0];

    localparam logic [SLOT_W-1:0] SLOT_EMPTY = '0;
    localparam logic [SLOT_W-1:0] SLOT_TOMB  = '1;
    localparam logic [CNT_W-1:0]  CNT_CAP    = CNT_W'(CAPACITY);
    localparam logic [BYTE_W-1:0] BYTE_LAST  = BYTE_W'(KEY_BYTES - 1);

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELETED  = 3'd4;

    localparam int IN_TDATA_W  = ((REQ_W + KEY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STAT_W + IDX_W + CNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic hash_step;
        logic probe_chk;
        logic key_chk;
        logic decide;
        logic move_rd;
        logic move_wr;
        logic move_chk;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hash_last;
        logic probe_last;
        logic slot_empty;
        logic slot_tomb;
        logic key_match;
        logic slot_is_last;
        logic need_move;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

>>> rtl/lpht_ram.sv
// ============================================================================
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/lpht_ctrl.sv
// ============================================================================
// lpht_ctrl
// Request sequencer: clear pass, hash, probe, decide, relocate, respond.
// ============================================================================
`default_nettype none

module lpht_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lpht_pkg::t_stat i_stat,
    output lpht_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_PREAD  = 4'd3;
    localparam logic [3:0] S_PCHK   = 4'd4;
    localparam logic [3:0] S_KCHK   = 4'd5;
    localparam logic [3:0] S_DECIDE = 4'd6;
    localparam logic [3:0] S_MVRD   = 4'd7;
    localparam logic [3:0] S_MVWR   = 4'd8;
    localparam logic [3:0] S_MHASH  = 4'd9;
    localparam logic [3:0] S_MREAD  = 4'd10;
    localparam logic [3:0] S_MCHK   = 4'd11;
    localparam logic [3:0] S_RESP   = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_PREAD;
                end
            end
            S_PREAD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                o_cmd.probe_chk = 1'b1;
                if (i_stat.slot_empty) begin
                    n_state = S_DECIDE;
                end else if (i_stat.slot_tomb) begin
                    n_state = i_stat.probe_last ? S_DECIDE : S_PREAD;
                end else begin
                    n_state = S_KCHK;
                end
            end
            S_KCHK: begin
                o_cmd.key_chk = 1'b1;
                if (i_stat.key_match || i_stat.probe_last) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_PREAD;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_stat.need_move ? S_MVRD : S_RESP;
            end
            S_MVRD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = S_MVWR;
            end
            S_MVWR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = S_MHASH;
            end
            S_MHASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) begin
                    n_state = S_MREAD;
                end
            end
            S_MREAD: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                o_cmd.move_chk = 1'b1;
                if (i_stat.slot_empty || i_stat.slot_is_last || i_stat.probe_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_MREAD;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/lpht_dp.sv
// ============================================================================
// lpht_dp
// Datapath: slot table and key store, FNV-1a hash unit, probe registers,
// live counter and result register.
// ============================================================================
`default_nettype none

module lpht_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lpht_pkg::t_cmd                    i_cmd,
    output lpht_pkg::t_stat                        o_stat,
    input  wire logic [lpht_pkg::REQ_W-1:0]        i_req,
    input  wire logic [lpht_pkg::KEY_W-1:0]        i_key,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [lpht_pkg::STAT_W-1:0]       o_status,
    output logic      [lpht_pkg::IDX_W-1:0]        o_entry_index,
    output logic      [lpht_pkg::CNT_W-1:0]        o_entry_count
);

    localparam int SAW = lpht_pkg::SLOT_AW;
    localparam int SW  = lpht_pkg::SLOT_W;
    localparam int IW  = lpht_pkg::IDX_W;
    localparam int CW  = lpht_pkg::CNT_W;

    logic [lpht_pkg::REQ_W-1:0]  r_req;
    logic [lpht_pkg::KEY_W-1:0]  r_key;
    logic [SAW-1:0]              r_hash;
    logic [lpht_pkg::BYTE_W-1:0] r_byte;
    logic [SAW-1:0]              r_pi;
    logic                        r_tomb_v;
    logic [SAW-1:0]              r_tomb;
    logic                        r_empty_v;
    logic [SAW-1:0]              r_empty;
    logic                        r_found;
    logic [SAW-1:0]              r_found_slot;
    logic [SW-1:0]               r_slot_v;
    logic [IW-1:0]               r_idx;
    logic [lpht_pkg::STAT_W-1:0] r_res;
    logic [CW-1:0]               r_count;
    logic [SAW-1:0]              r_clr;
    logic                        r_out_valid;
    logic [lpht_pkg::STAT_W-1:0] r_out_status;
    logic [IW-1:0]               r_out_idx;
    logic [CW-1:0]               r_out_count;

    logic [SAW-1:0]              probe;
    logic [SW-1:0]               slot_rd;
    logic [lpht_pkg::KEY_W-1:0]  key_rd;
    logic [7:0]                  cur_byte;
    logic [SAW-1:0]              hx;
    logic [2*SAW-1:0]            hprod;
    logic [IW-1:0]               v_idx;
    logic [IW-1:0]               rd_idx;
    logic                        is_ins;
    logic                        is_del;
    logic                        free_ok;
    logic [SAW-1:0]              free_slot;
    logic                        full;
    logic                        ins_ok;
    logic                        del_ok;
    logic                        last_hit;
    logic                        hash_init;

    logic                        slot_we;
    logic [SAW-1:0]              slot_wa;
    logic [SW-1:0]               slot_wd;
    logic                        key_we;
    logic [IW-1:0]               key_wa;
    logic [lpht_pkg::KEY_W-1:0]  key_wd;
    logic [IW-1:0]               key_ra;

    assign probe    = r_hash + r_pi;
    assign cur_byte = r_key[r_byte * 8 +: 8];
    assign hx       = r_hash ^ SAW'(cur_byte);
    assign hprod    = {{SAW{1'b0}}, hx} * {{SAW{1'b0}}, lpht_pkg::FNV_PRIME_LO};

    assign v_idx     = IW'(r_slot_v - SW'(1));
    assign rd_idx    = IW'(slot_rd - SW'(1));
    assign is_ins    = (r_req == lpht_pkg::REQ_INSERT);
    assign is_del    = (r_req == lpht_pkg::REQ_DELETE);
    assign free_ok   = r_tomb_v || r_empty_v;
    assign free_slot = r_tomb_v ? r_tomb : r_empty;
    assign full      = (r_count >= lpht_pkg::CNT_CAP) || !free_ok;
    assign ins_ok    = is_ins && !r_found && !full;
    assign del_ok    = is_del && r_found;
    assign last_hit  = (slot_rd == ({1'b0, r_count} + SW'(1)));
    assign hash_init = i_cmd.load || i_cmd.move_wr;

    // slot table write port
    always_comb begin
        slot_we = 1'b0;
        slot_wa = probe;
        slot_wd = lpht_pkg::SLOT_EMPTY;
        if (i_cmd.clr_wr) begin
            slot_we = 1'b1;
            slot_wa = r_clr;
        end else if (i_cmd.decide && ins_ok) begin
            slot_we = 1'b1;
            slot_wa = free_slot;
            slot_wd = {1'b0, r_count} + SW'(1);
        end else if (i_cmd.decide && del_ok) begin
            slot_we = 1'b1;
            slot_wa = r_found_slot;
            slot_wd = lpht_pkg::SLOT_TOMB;
        end else if (i_cmd.move_chk && last_hit) begin
            slot_we = 1'b1;
            slot_wd = SW'(r_idx) + SW'(1);
        end
    end

    // key store ports
    always_comb begin
        key_we = 1'b0;
        key_wa = r_count[IW-1:0];
        key_wd = r_key;
        if (i_cmd.decide && ins_ok) begin
            key_we = 1'b1;
        end else if (i_cmd.move_wr) begin
            key_we = 1'b1;
            key_wa = r_idx;
            key_wd = key_rd;
        end
        key_ra = i_cmd.move_rd ? r_count[IW-1:0] : rd_idx;
    end

    lpht_ram #(
        .WIDTH (SW),
        .DEPTH (lpht_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_wa),
        .i_wdata (slot_wd),
        .i_raddr (probe),
        .o_rdata (slot_rd)
    );

    lpht_ram #(
        .WIDTH (lpht_pkg::KEY_W),
        .DEPTH (lpht_pkg::CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_wa),
        .i_wdata (key_wd),
        .i_raddr (key_ra),
        .o_rdata (key_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + SAW'(1);
            end
            if (i_cmd.decide && ins_ok) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.decide && del_ok) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_key <= i_key & lpht_pkg::KEY_MASK;
        end else if (i_cmd.move_wr) begin
            r_key <= key_rd;
        end

        if (hash_init) begin
            r_hash    <= lpht_pkg::FNV_BASIS_LO;
            r_byte    <= '0;
            r_pi      <= '0;
            r_tomb_v  <= 1'b0;
            r_empty_v <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_cmd.hash_step) begin
            r_hash <= hprod[SAW-1:0];
            r_byte <= r_byte + lpht_pkg::BYTE_W'(1);
        end

        if (i_cmd.probe_chk) begin
            r_slot_v <= slot_rd;
            if (slot_rd == lpht_pkg::SLOT_EMPTY) begin
                r_empty_v <= 1'b1;
                r_empty   <= probe;
            end else if (slot_rd == lpht_pkg::SLOT_TOMB) begin
                if (!r_tomb_v) begin
                    r_tomb_v <= 1'b1;
                    r_tomb   <= probe;
                end
                r_pi <= r_pi + SAW'(1);
            end
        end

        if (i_cmd.key_chk) begin
            if (key_rd == r_key) begin
                r_found      <= 1'b1;
                r_found_slot <= probe;
            end else begin
                r_pi <= r_pi + SAW'(1);
            end
        end

        if (i_cmd.move_chk) begin
            r_pi <= r_pi + SAW'(1);
        end

        if (i_cmd.decide) begin
            if (is_ins) begin
                if (r_found) begin
                    r_res <= lpht_pkg::ST_FOUND;
                    r_idx <= v_idx;
                end else if (full) begin
                    r_res <= lpht_pkg::ST_FULL;
                    r_idx <= '0;
                end else begin
                    r_res <= lpht_pkg::ST_INSERTED;
                    r_idx <= r_count[IW-1:0];
                end
            end else if (r_found) begin
                r_res <= is_del ? lpht_pkg::ST_DELETED : lpht_pkg::ST_FOUND;
                r_idx <= v_idx;
            end else begin
                r_res <= lpht_pkg::ST_NOTFOUND;
                r_idx <= '0;
            end
        end

        if (i_cmd.out_load) begin
            r_out_status <= r_res;
            r_out_idx    <= r_idx;
            r_out_count  <= r_count;
        end
    end

    assign o_stat.clr_last     = &r_clr;
    assign o_stat.hash_last    = (r_byte == lpht_pkg::BYTE_LAST);
    assign o_stat.probe_last   = &r_pi;
    assign o_stat.slot_empty   = (slot_rd == lpht_pkg::SLOT_EMPTY);
    assign o_stat.slot_tomb    = (slot_rd == lpht_pkg::SLOT_TOMB);
    assign o_stat.key_match    = (key_rd == r_key);
    assign o_stat.slot_is_last = last_hit;
    // delete of anything but the last dense entry moves the last key down
    assign o_stat.need_move    = del_ok && ({1'b0, v_idx} != (r_count - CW'(1)));
    assign o_stat.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_entry_count = r_out_count;

endmodule

`default_nettype wire

>>> rtl/linear_probe_hash_table.sv
// ============================================================================
// linear_probe_hash_table
// Fixed-capacity hash set: lookup, insert and delete of 64-bit keys with
// FNV-1a hashing, linear probing over a 2x slot table and a dense key array.
// ============================================================================
// One request is handled at a time. After reset the block sweeps the
// 512-entry slot table to empty, one slot per cycle, with the input not
// ready. A request is then accepted, its key bytes are folded through the
// hash one byte per cycle, and each probed slot takes a registered slot
// table read plus, when the slot holds a live entry, a registered key store
// read and compare; the block then decides and loads the result register.
// A delete that moves the last key into the gap adds the move, a rehash of
// that key and a slot table read and check per slot searched for its
// pointer. The probe walk is the variable part; at low load it is one or
// two slots. The result register lets the next request be accepted while
// the previous result is still waiting on the output.
// Status codes: 0 found, 1 not found, 2 inserted new, 3 table full, 4 deleted.
// ============================================================================
`default_nettype none

module linear_probe_hash_table (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request stream
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [1:0] req_type, [65:2] key, [71:66] zero
    input  wire logic [lpht_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // result stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [2:0] status, [10:3] entry_index, [19:11] entry_count, [23:20] zero
    output logic      [lpht_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int RW = lpht_pkg::REQ_W;
    localparam int KW = lpht_pkg::KEY_W;
    localparam int PW = lpht_pkg::STAT_W + lpht_pkg::IDX_W + lpht_pkg::CNT_W;

    lpht_pkg::t_cmd              cmd;
    lpht_pkg::t_stat             stat;
    logic [lpht_pkg::STAT_W-1:0] status;
    logic [lpht_pkg::IDX_W-1:0]  entry_index;
    logic [lpht_pkg::CNT_W-1:0]  entry_count;

    // sequencer: owns the state machine and the input handshake
    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: memories, hash, probe tracking, result register
    lpht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req         (i_s_axis_tdata[RW-1:0]),
        .i_key         (i_s_axis_tdata[RW +: KW]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (status),
        .o_entry_index (entry_index),
        .o_entry_count (entry_count)
    );

    assign o_m_axis_tdata = {{(lpht_pkg::OUT_TDATA_W - PW){1'b0}},
                             entry_count, entry_index, status};

endmodule

`default_nettype wire

>>> sim/linear_probe_hash_table_tb.sv
// ============================================================================
// linear_probe_hash_table_tb
// Self-checking bench for the hash set: drives lookup, insert and delete
// transactions, predicts each result with a behavioral copy of the table and
// compares every field of every result transaction.
// ============================================================================
`default_nettype none

module linear_probe_hash_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_TOMB_I = -1;
    localparam longint unsigned CYCLE_LIMIT = 20_000_000;
    localparam logic [lpht_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [lpht_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [lpht_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    linear_probe_hash_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [lpht_pkg::STAT_W-1:0] status;
        logic [lpht_pkg::IDX_W-1:0]  index;
        logic [lpht_pkg::CNT_W-1:0]  count;
    } t_result;

    // predicted hash set contents
    int                         slot_map[lpht_pkg::SLOTS]; // 0 empty, -1 tomb, else index+1
    logic [lpht_pkg::KEY_W-1:0] key_store[lpht_pkg::CAPACITY];
    int                         live_entries;

    t_result    pending_results[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    longint unsigned cycles = 0;

    function automatic logic [63:0] fnv1a(logic [63:0] k);
        logic [63:0] h;
        h = lpht_pkg::FNV_BASIS;
        for (int i = 0; i < lpht_pkg::KEY_BYTES; i++) begin
            h = h ^ 64'((k >> (8 * i)) & 64'hff);
            h = h * lpht_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    // probe for key; returns slot or SLOTS, free_slot gets first reusable slot
    function automatic int probe_key(logic [63:0] k, output int free_slot);
        logic [63:0] h;
        int tomb, p;
        h = fnv1a(k);
        tomb = lpht_pkg::SLOTS;
        for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
            p = int'((h + 64'(i)) % 64'(lpht_pkg::SLOTS));
            if (slot_map[p] == 0) begin
                free_slot = (tomb != lpht_pkg::SLOTS) ? tomb : p;
                return lpht_pkg::SLOTS;
            end
            if (slot_map[p] == SLOT_TOMB_I) begin
                if (tomb == lpht_pkg::SLOTS) tomb = p;
            end else if (key_store[slot_map[p] - 1] == k) begin
                return p;
            end
        end
        free_slot = tomb;
        return lpht_pkg::SLOTS;
    endfunction

    function automatic t_result apply_request(logic [1:0] req, logic [63:0] key_in);
        t_result r;
        logic [63:0] k, mk, h;
        int s, free_slot, idx, last, p;
        k = key_in & lpht_pkg::KEY_MASK;
        free_slot = lpht_pkg::SLOTS;
        s = probe_key(k, free_slot);
        idx = 0;
        if (req == lpht_pkg::REQ_INSERT) begin
            if (s != lpht_pkg::SLOTS) begin
                r.status = lpht_pkg::ST_FOUND;
                idx = slot_map[s] - 1;
            end else if (live_entries >= lpht_pkg::CAPACITY ||
                         free_slot == lpht_pkg::SLOTS) begin
                r.status = lpht_pkg::ST_FULL;
            end else begin
                idx = live_entries;
                key_store[idx] = k;
                live_entries++;
                slot_map[free_slot] = live_entries;
                r.status = lpht_pkg::ST_INSERTED;
            end
        end else if (req == lpht_pkg::REQ_DELETE) begin
            if (s == lpht_pkg::SLOTS) begin
                r.status = lpht_pkg::ST_NOTFOUND;
            end else begin
                idx = slot_map[s] - 1;
                slot_map[s] = SLOT_TOMB_I;
                live_entries--;
                last = live_entries;
                if (idx != last) begin
                    // move last key into the gap and repoint its slot
                    mk = key_store[last];
                    key_store[idx] = mk;
                    h = fnv1a(mk);
                    for (int j = 0; j < lpht_pkg::SLOTS; j++) begin
                        p = int'((h + 64'(j)) % 64'(lpht_pkg::SLOTS));
                        if (slot_map[p] == 0) break;
                        if (slot_map[p] == last + 1) begin
                            slot_map[p] = idx + 1;
                            break;
                        end
                    end
                end
                r.status = lpht_pkg::ST_DELETED;
            end
        end else begin
            // lookup, and the unused code behaves the same
            if (s != lpht_pkg::SLOTS) begin
                r.status = lpht_pkg::ST_FOUND;
                idx = slot_map[s] - 1;
            end else begin
                r.status = lpht_pkg::ST_NOTFOUND;
            end
        end
        r.index = lpht_pkg::IDX_W'(idx);
        r.count = lpht_pkg::CNT_W'(live_entries);
        return r;
    endfunction

    // one request transaction; prediction made at acceptance
    task automatic send_request(logic [1:0] req, logic [63:0] k);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  <= lpht_pkg::IN_TDATA_W'({k, req});
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(apply_request(req, k));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_axis_tready <= 1'b0;
        else i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[2:0], o_m_axis_tdata[10:3], o_m_axis_tdata[19:11]};
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.index !== want.index) begin
                    $error("entry_index: expected %0d, got %0d", want.index, got.index);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // keys in use, reused so lookups and deletes hit
    logic [63:0] known_keys[$];

    function automatic logic [63:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(3) != 0)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_request(lpht_pkg::REQ_LOOKUP, 64'h0);                  // empty table
        send_request(lpht_pkg::REQ_DELETE, 64'hffff_ffff_ffff_ffff); // delete absent
        send_request(lpht_pkg::REQ_INSERT, 64'h0);
        send_request(lpht_pkg::REQ_INSERT, 64'hffff_ffff_ffff_ffff);
        send_request(lpht_pkg::REQ_INSERT, 64'h5555_aaaa_5555_aaaa);
        send_request(lpht_pkg::REQ_INSERT, 64'h0);                  // present key
        send_request(lpht_pkg::REQ_LOOKUP, 64'hffff_ffff_ffff_ffff);
        send_request(REQ_SPARE, 64'h5555_aaaa_5555_aaaa);           // unused code
        send_request(lpht_pkg::REQ_DELETE, 64'h0);                  // moves last key
        send_request(lpht_pkg::REQ_LOOKUP, 64'h5555_aaaa_5555_aaaa);
        send_request(lpht_pkg::REQ_DELETE, 64'h5555_aaaa_5555_aaaa); // moved key; moves last key again
        send_request(lpht_pkg::REQ_INSERT, 64'h0);                  // reuse tombstone
        send_request(lpht_pkg::REQ_DELETE, 64'h0);
        send_request(lpht_pkg::REQ_DELETE, 64'hffff_ffff_ffff_ffff);
        wait_drained();
    endtask

    // fill to capacity, hit the full case, then empty again
    task automatic test_full_table();
        logic [63:0] k;
        known_keys.delete();
        while (live_entries < lpht_pkg::CAPACITY) begin
            k = {$urandom(), $urandom()};
            known_keys.push_back(k);
            send_request(lpht_pkg::REQ_INSERT, k);
        end
        send_request(lpht_pkg::REQ_INSERT, 64'h1234_5678_9abc_def0);
        send_request(lpht_pkg::REQ_INSERT, known_keys[0]);
        wait_drained();
        while (known_keys.size() != 0) begin
            k = known_keys[$urandom_range(known_keys.size() - 1)];
            send_request(lpht_pkg::REQ_DELETE, k);
            foreach (known_keys[i]) if (known_keys[i] == k) begin
                known_keys.delete(i);
                break;
            end
        end
        wait_drained();
    endtask

    task automatic test_random(int n);
        logic [63:0] k;
        logic [1:0] req;
        for (int i = 0; i < n; i++) begin
            k = pick_key();
            case ($urandom_range(9))
                0, 1, 2, 3: req = lpht_pkg::REQ_INSERT;
                4, 5, 6:    req = lpht_pkg::REQ_LOOKUP;
                7, 8:       req = lpht_pkg::REQ_DELETE;
                default:    req = REQ_SPARE;
            endcase
            if (req == lpht_pkg::REQ_INSERT && known_keys.size() < 200)
                known_keys.push_back(k);
            send_request(req, k);
        end
    endtask

    initial begin
        live_entries = 0;
        foreach (slot_map[i]) slot_map[i] = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 36; recv_idle_pct = 66;
        test_directed();
        test_random(100);
        wait_drained();     // sender holds until every result is back
        send_idle_pct = 66; recv_idle_pct = 36;
        test_full_table();
        test_random(100);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(100);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table.sv
sim/linear_probe_hash_table_tb.sv
